// ===== hdl/pawl_pkg.sv =====
// ----------------------------------------------------------------------------
// pawl_pkg
// Shared types and constants of the per-address fixed-window limiter.
// ----------------------------------------------------------------------------
package pawl_pkg;

   // Table geometry
   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int ISS_W   = $clog2(ENTRIES + 1);

   // Field widths
   localparam int ADDR_W = 64;
   localparam int TIME_W = 64;
   localparam int CNT_W  = 11;
   localparam int WIN_W  = 17;
   localparam int STS_W  = 2;

   // Policy bounds
   localparam logic [CNT_W-1:0] MAX_ATTEMPT_LIMIT = CNT_W'(1024);
   localparam logic [WIN_W-1:0] MAX_WINDOW        = WIN_W'(86400);
   localparam logic [CNT_W-1:0] LIMIT_RESET       = CNT_W'(5);
   localparam logic [WIN_W-1:0] WINDOW_RESET      = WIN_W'(3600);

   // Register indexes
   localparam logic REG_ATTEMPT_LIMIT = 1'b0;
   localparam logic REG_WINDOW_LENGTH = 1'b1;

   // Result codes
   typedef enum logic [STS_W-1:0] {
      STS_ALLOWED      = 2'd0,
      STS_RATE_LIMITED = 2'd1,
      STS_TABLE_FULL   = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // One table row held in memory
   typedef struct packed {
      logic              family;
      logic [ADDR_W-1:0] addr_high;
      logic [ADDR_W-1:0] addr_low;
      logic [CNT_W-1:0]  count;
      logic [TIME_W-1:0] start;
   } row_type;

   // Row write command
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      row_type          row;
   } row_wr_type;

   // Valid flag updates
   typedef struct packed {
      logic             clr_en;
      logic [IDX_W-1:0] clr_idx;
      logic             set_en;
      logic [IDX_W-1:0] set_idx;
   } vld_op_type;

endpackage

// ===== hdl/per_address_fixed_window_limiter.sv =====
// ----------------------------------------------------------------------------
// per_address_fixed_window_limiter
// Fixed-window attempt limiter keyed by address family and 128-bit address.
// ----------------------------------------------------------------------------
// Each request item is one attempt and yields exactly one response item. The
// table of 64 entries sits in a row memory with one read and one write port;
// the controller sweeps it one entry per cycle through a two-stage evaluation
// pipeline behind the memory's registered read, freeing expired entries as it
// goes and stopping at the first live match. Each item scans at most 64
// entries, then its row is written back if allowed and its result posted.
// The response sits in an output register; the next request is taken while
// it waits. The table is empty after reset, with no clearing pass.
// Configuration writes are always accepted and should be made while idle.
// ----------------------------------------------------------------------------
module per_address_fixed_window_limiter
   import pawl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request: tdata = address_high[63:0], address_low[127:64], current_time[191:128]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,
   // request: tuser = family[0]
   input  logic         req_tuser,
   // response: tdata = retry_after[16:0], zero fill [23:17]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,
   // response: tuser = status[1:0]
   output logic [1:0]   rsp_tuser,
   // configuration write
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [16:0]  csr_data
);

   state_type          state_ff, state_in;

   // Configuration
   logic [CNT_W-1:0]   limit_ff;
   logic [WIN_W-1:0]   window_ff;
   logic [CNT_W-1:0]   lim;
   logic [WIN_W-1:0]   win;

   // Latched request
   logic               fam_ff;
   logic [ADDR_W-1:0]  ah_ff, al_ff;
   logic [TIME_W-1:0]  now_ff;

   // Scan issue and pipeline
   logic [ISS_W-1:0]   iss_cnt_ff;
   logic               d_vld_ff;
   logic [IDX_W-1:0]   d_idx_ff;
   logic               a_vld_ff;
   logic [IDX_W-1:0]   a_idx_ff;
   logic               a_hit_ff;
   logic [TIME_W:0]    a_diff_ff;
   logic [CNT_W-1:0]   a_count_ff;
   logic [TIME_W-1:0]  a_start_ff;

   // Scan summary
   logic               have_free_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic               have_retry_ff;
   logic [WIN_W-1:0]   least_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   match_idx_ff;
   logic [CNT_W-1:0]   match_count_ff;
   logic [TIME_W-1:0]  match_start_ff;
   logic [WIN_W-1:0]   match_rem_ff;

   // Response register
   logic               rsp_vld_ff;
   status_type         rsp_sts_ff;
   logic [WIN_W-1:0]   rsp_retry_ff;

   // Control from the state machine
   logic               accept;
   logic               issue;
   logic               eval;
   logic               fin_go;

   // Stage B
   logic               b_live;
   logic               b_hit;
   logic               b_last;
   logic               scan_done;
   logic [WIN_W-1:0]   b_rem;

   // Table interface
   row_type            rd_row;
   row_wr_type         wr;
   vld_op_type         vld_op;
   logic [ENTRIES-1:0] valid;

   // Finish decisions
   logic               under_limit;
   status_type         fin_sts;
   logic [WIN_W-1:0]   fin_retry;

   pawl_table u_table (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (issue),
      .rd_idx (iss_cnt_ff[IDX_W-1:0]),
      .rd_row (rd_row),
      .wr     (wr),
      .vld_op (vld_op),
      .valid  (valid)
   );

   // Clamp the policy registers
   always_comb begin
      lim = limit_ff;
      if (limit_ff == '0) begin
         lim = CNT_W'(1);
      end else if (limit_ff > MAX_ATTEMPT_LIMIT) begin
         lim = MAX_ATTEMPT_LIMIT;
      end
      win = window_ff;
      if (window_ff == '0) begin
         win = WIN_W'(1);
      end else if (window_ff > MAX_WINDOW) begin
         win = MAX_WINDOW;
      end
   end

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_RESET;
         window_ff <= WINDOW_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ATTEMPT_LIMIT: limit_ff  <= csr_data[CNT_W-1:0];
            REG_WINDOW_LENGTH: window_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage B: judge one entry against the current time
   assign b_live = valid[a_idx_ff] && !a_diff_ff[TIME_W]
                   && (a_diff_ff[TIME_W-1:WIN_W] == '0)
                   && (a_diff_ff[WIN_W-1:0] < win);
   assign b_rem     = win - a_diff_ff[WIN_W-1:0];
   assign b_hit     = eval && b_live && a_hit_ff;
   assign b_last    = (a_idx_ff == IDX_W'(ENTRIES - 1));
   assign scan_done = eval && (b_hit || b_last);

   // Free expired entries, take the free slot at finish
   always_comb begin
      vld_op         = '0;
      vld_op.clr_en  = eval && valid[a_idx_ff] && !b_live;
      vld_op.clr_idx = a_idx_ff;
      vld_op.set_en  = fin_go && !found_ff && have_free_ff;
      vld_op.set_idx = free_idx_ff;
   end

   // Finish: decide the result and the write-back
   assign under_limit = match_count_ff < lim;

   always_comb begin
      wr                = '0;
      fin_sts           = STS_ALLOWED;
      fin_retry         = '0;
      wr.row.family     = fam_ff;
      wr.row.addr_high  = ah_ff;
      wr.row.addr_low   = al_ff;
      if (found_ff) begin
         wr.idx        = match_idx_ff;
         wr.row.count  = match_count_ff + CNT_W'(1);
         wr.row.start  = match_start_ff;
         if (under_limit) begin
            wr.en = fin_go;
         end else begin
            fin_sts   = STS_RATE_LIMITED;
            fin_retry = match_rem_ff;
         end
      end else if (!have_free_ff) begin
         fin_sts   = STS_TABLE_FULL;
         fin_retry = have_retry_ff ? least_ff : WIN_W'(1);
      end else begin
         wr.en        = fin_go;
         wr.idx       = free_idx_ff;
         wr.row.count = CNT_W'(1);
         wr.row.start = now_ff;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_SCAN;
         ST_SCAN:   if (scan_done) state_in = ST_FINISH;
         ST_FINISH: if (!rsp_vld_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State machine outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      eval       = 1'b0;
      fin_go     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_SCAN: begin
            issue = (iss_cnt_ff < ISS_W'(ENTRIES)) && !scan_done;
            eval  = a_vld_ff;
         end
         ST_FINISH: fin_go = !rsp_vld_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the request
   always_ff @(posedge clock) begin
      if (accept) begin
         fam_ff <= req_tuser;
         ah_ff  <= req_tdata[63:0];
         al_ff  <= req_tdata[127:64];
         now_ff <= req_tdata[191:128];
      end
   end

   // Issue counter and pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_cnt_ff <= '0;
         d_vld_ff   <= 1'b0;
         a_vld_ff   <= 1'b0;
      end else if (accept) begin
         iss_cnt_ff <= '0;
         d_vld_ff   <= 1'b0;
         a_vld_ff   <= 1'b0;
      end else begin
         if (issue) begin
            iss_cnt_ff <= iss_cnt_ff + ISS_W'(1);
         end
         d_vld_ff <= issue;
         a_vld_ff <= d_vld_ff;
      end
   end

   // Stage A: address compare and elapsed time
   always_ff @(posedge clock) begin
      d_idx_ff   <= iss_cnt_ff[IDX_W-1:0];
      a_idx_ff   <= d_idx_ff;
      a_hit_ff   <= (rd_row.family == fam_ff) && (rd_row.addr_high == ah_ff)
                    && (rd_row.addr_low == al_ff);
      a_diff_ff  <= {1'b0, now_ff} - {1'b0, rd_row.start};
      a_count_ff <= rd_row.count;
      a_start_ff <= rd_row.start;
   end

   // Accumulate free slot, least remaining time and match
   always_ff @(posedge clock) begin
      if (reset) begin
         have_free_ff  <= 1'b0;
         have_retry_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else if (accept) begin
         have_free_ff  <= 1'b0;
         have_retry_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else if (eval) begin
         if (!b_live && !have_free_ff) begin
            have_free_ff <= 1'b1;
            free_idx_ff  <= a_idx_ff;
         end
         if (b_live && !a_hit_ff && (!have_retry_ff || b_rem < least_ff)) begin
            have_retry_ff <= 1'b1;
            least_ff      <= b_rem;
         end
         if (b_hit) begin
            found_ff       <= 1'b1;
            match_idx_ff   <= a_idx_ff;
            match_count_ff <= a_count_ff;
            match_start_ff <= a_start_ff;
            match_rem_ff   <= b_rem;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_sts_ff   <= fin_sts;
         rsp_retry_ff <= fin_retry;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_sts_ff;
   assign rsp_tdata  = {7'b0, rsp_retry_ff};

endmodule

// ===== hdl/pawl_table.sv =====
// ----------------------------------------------------------------------------
// pawl_table
// Entry store: one synchronous row memory with registered read data, and the
// per-entry valid flags in flip-flops cleared at reset.
// ----------------------------------------------------------------------------
module pawl_table
   import pawl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_idx,
   output row_type            rd_row,
   input  row_wr_type         wr,
   input  vld_op_type         vld_op,
   output logic [ENTRIES-1:0] valid
);

   row_type            mem [ENTRIES];
   row_type            rd_row_ff;
   logic [ENTRIES-1:0] valid_ff;

   // Write and read the row memory
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.row;
      end
      if (rd_en) begin
         rd_row_ff <= mem[rd_idx];
      end
   end

   // Clear expired entries, set newly taken ones
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (vld_op.clr_en) begin
            valid_ff[vld_op.clr_idx] <= 1'b0;
         end
         if (vld_op.set_en) begin
            valid_ff[vld_op.set_idx] <= 1'b1;
         end
      end
   end

   assign rd_row = rd_row_ff;
   assign valid  = valid_ff;

endmodule
